// ===== rtl/rwt_pkg.sv =====
`default_nettype none

package rwt_pkg;

  localparam int MAX_TOKENS     = 20;
  localparam int MAX_WORD_CHARS = 6;
  localparam int GROUP_CHARS    = 3;

  localparam int CODE_W  = 6;
  localparam int WORD_W  = 16;
  localparam int COUNT_W = 5;
  localparam int CHARS_W = 3;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CH_EOL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PERIOD = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ONE    = 8'h31;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A      = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z      = 8'h5A;

  localparam logic [CHAR_W-1:0] LETTER_OFFSET = CH_A - 8'd1;
  localparam logic [CHAR_W-1:0] DIGIT_OFFSET  = CH_ONE - 8'd31;
  localparam logic [CODE_W-1:0] HYPHEN_CODE   = 6'd27;

  localparam logic [11:0] WEIGHT_HIGH = 12'd1600;
  localparam logic [11:0] WEIGHT_MID  = 12'd40;

  localparam logic [COUNT_W-1:0] TOKEN_LIMIT = COUNT_W'(MAX_TOKENS);
  localparam logic [CHARS_W-1:0] CHAR_LIMIT  = CHARS_W'(MAX_WORD_CHARS);
  localparam logic [CHARS_W-1:0] GROUP_SIZE  = CHARS_W'(GROUP_CHARS);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ILLEGAL  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_SCAN    = 2'd0,
    MODE_DISCARD = 2'd1,
    MODE_CLOSED  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_EOL,
    KIND_PUNCT,
    KIND_SPACE,
    KIND_SYMBOL,
    KIND_ILLEGAL
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CODE_W-1:0] code;
  } char_class_t;

  typedef struct packed {
    logic [WORD_W-1:0]  first_word;
    logic [WORD_W-1:0]  second_word;
    logic               token_valid;
    logic               end_of_command;
    status_t            status;
    logic [COUNT_W-1:0] token_count;
  } result_t;

  function automatic logic [WORD_W-1:0] place_product(input logic [CODE_W-1:0] v,
                                                       input logic [1:0] pos);
    logic [WORD_W-1:0] p;
    begin
      unique case (pos)
        2'd0:    p = {10'd0, v} * WORD_W'(WEIGHT_HIGH);
        2'd1:    p = {10'd0, v} * WORD_W'(WEIGHT_MID);
        default: p = WORD_W'(v);
      endcase
      return p;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rwt_classify.sv =====
`default_nettype none

module rwt_classify
  import rwt_pkg::*;
(
  input  wire logic [CHAR_W-1:0] character,
  output char_class_t            cls
);

  logic [CHAR_W-1:0] diff;

  always_comb begin
    cls.code = '0;
    diff     = '0;
    priority if (character == CH_EOL) begin
      cls.kind = KIND_EOL;
    end else if (character == CH_PERIOD || character == CH_COMMA) begin
      cls.kind = KIND_PUNCT;
    end else if (character == CH_SPACE) begin
      cls.kind = KIND_SPACE;
    end else if (character >= CH_A && character <= CH_Z) begin
      cls.kind = KIND_SYMBOL;
      diff     = character - LETTER_OFFSET;
      cls.code = diff[CODE_W-1:0];
    end else if (character >= CH_ONE && character <= CH_NINE) begin
      cls.kind = KIND_SYMBOL;
      diff     = character - DIGIT_OFFSET;
      cls.code = diff[CODE_W-1:0];
    end else if (character == CH_HYPHEN) begin
      cls.kind = KIND_SYMBOL;
      cls.code = HYPHEN_CODE;
    end else begin
      cls.kind = KIND_ILLEGAL;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rwt_scan.sv =====
`default_nettype none

module rwt_scan
  import rwt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  accept,
  input  wire char_class_t cls,
  output logic       res_valid,
  output result_t    res
);

  mode_t              mode_r, mode_nxt;
  logic [CHARS_W-1:0] chars_r, chars_nxt;
  logic [WORD_W-1:0]  acc1_r, acc1_nxt;
  logic [WORD_W-1:0]  acc2_r, acc2_nxt;
  logic [COUNT_W-1:0] tokens_r, tokens_nxt;
  logic               ovf_r, ovf_nxt;

  logic               ending;
  logic               word_open;
  logic               room;
  logic [CHARS_W-1:0] pos;
  logic [WORD_W-1:0]  prod;
  status_t            st;

  assign ending    = (cls.kind == KIND_EOL) || (cls.kind == KIND_PUNCT);
  assign word_open = (chars_r != '0);
  assign room      = (tokens_r < TOKEN_LIMIT);
  assign pos       = (chars_r < GROUP_SIZE) ? chars_r : chars_r - GROUP_SIZE;
  assign prod      = place_product(cls.code, pos[1:0]);

  always_comb begin
    mode_nxt   = mode_r;
    chars_nxt  = chars_r;
    acc1_nxt   = acc1_r;
    acc2_nxt   = acc2_r;
    tokens_nxt = tokens_r;
    ovf_nxt    = ovf_r;
    res_valid  = 1'b0;
    res        = '0;
    st         = ST_OK;
    if (accept) begin
      if (mode_r == MODE_DISCARD) begin
        if (cls.kind == KIND_EOL) begin
          mode_nxt = MODE_SCAN;
        end
      end else if (!(mode_r == MODE_CLOSED && cls.kind == KIND_EOL)) begin
        mode_nxt = MODE_SCAN;
        unique case (cls.kind)
          KIND_EOL, KIND_PUNCT: begin
            if (word_open) begin
              if (room) begin
                tokens_nxt      = tokens_r + 1'b1;
                res.first_word  = acc1_r;
                res.second_word = acc2_r;
                res.token_valid = 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            priority if (ovf_nxt) begin
              st = ST_OVERFLOW;
            end else if (tokens_nxt == '0) begin
              st = ST_EMPTY;
            end else begin
              st = ST_OK;
            end
            res_valid          = 1'b1;
            res.end_of_command = 1'b1;
            res.status         = st;
            res.token_count    = tokens_nxt;
            if (cls.kind == KIND_PUNCT) begin
              mode_nxt = (st == ST_OK) ? MODE_CLOSED : MODE_DISCARD;
            end
            chars_nxt  = '0;
            acc1_nxt   = '0;
            acc2_nxt   = '0;
            tokens_nxt = '0;
            ovf_nxt    = 1'b0;
          end
          KIND_SPACE: begin
            if (word_open) begin
              if (room) begin
                tokens_nxt      = tokens_r + 1'b1;
                res_valid       = 1'b1;
                res.first_word  = acc1_r;
                res.second_word = acc2_r;
                res.token_valid = 1'b1;
                res.token_count = tokens_nxt;
              end else begin
                ovf_nxt = 1'b1;
              end
              chars_nxt = '0;
              acc1_nxt  = '0;
              acc2_nxt  = '0;
            end
          end
          KIND_ILLEGAL: begin
            res_valid          = 1'b1;
            res.end_of_command = 1'b1;
            res.status         = ST_ILLEGAL;
            res.token_count    = tokens_r;
            chars_nxt          = '0;
            acc1_nxt           = '0;
            acc2_nxt           = '0;
            tokens_nxt         = '0;
            ovf_nxt            = 1'b0;
            mode_nxt           = MODE_DISCARD;
          end
          default: begin
            if (chars_r < CHAR_LIMIT) begin
              if (chars_r < GROUP_SIZE) begin
                acc1_nxt = acc1_r + prod;
              end else begin
                acc2_nxt = acc2_r + prod;
              end
              chars_nxt = chars_r + 1'b1;
            end
          end
        endcase
      end else begin
        // end of line right after a clean close
        mode_nxt = MODE_SCAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SCAN;
      chars_r  <= '0;
      acc1_r   <= '0;
      acc2_r   <= '0;
      tokens_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      chars_r  <= chars_nxt;
      acc1_r   <= acc1_nxt;
      acc2_r   <= acc2_nxt;
      tokens_r <= tokens_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rwt_out_buf.sv =====
`default_nettype none

module rwt_out_buf
  import rwt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire result_t push_data,
  output logic      space,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_data
);

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    take;

  assign take      = main_v_r && out_ready;
  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (push) begin
      if (!main_v_r || take) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/radix40_word_tokenizer.sv =====
// radix-40 word tokenizer
// input channel: one character per transfer on in_character, in_valid/in_ready;
//   code 0 is end of line, period and comma close a command
// result channel: out_valid/out_ready with out_first_word, out_second_word,
//   out_token_valid, out_end_of_command, out_status and out_token_count;
//   a character yields zero or one result
// output: a taken character's result is registered into the output register,
//   or into the skid register while the output register holds a waiting result
// throughput: one character per cycle while in_ready is high; per-character
//   work is a classify and a constant-weight accumulate into word registers
// stall: a two-entry output stage (output register plus skid register)
//   keeps in_ready high while one result waits; in_ready drops only when
//   both entries hold results
// reset: synchronous; rst_n low at a clock edge clears the scan state, the word
//   accumulators, the token count and both output entries
`default_nettype none

module radix40_word_tokenizer
  import rwt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [CHAR_W-1:0]   in_character,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [WORD_W-1:0]        out_first_word,
  output logic [WORD_W-1:0]        out_second_word,
  output logic                     out_token_valid,
  output logic                     out_end_of_command,
  output logic [1:0]               out_status,
  output logic [COUNT_W-1:0]       out_token_count
);

  char_class_t cls;
  logic        accept;
  logic        res_valid;
  result_t     res;
  result_t     out_data;
  logic        space;

  assign in_ready = space;
  assign accept   = in_valid && space;

  rwt_classify u_classify (
    .character (in_character),
    .cls       (cls)
  );

  rwt_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cls       (cls),
    .res_valid (res_valid),
    .res       (res)
  );

  rwt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_first_word     = out_data.first_word;
  assign out_second_word    = out_data.second_word;
  assign out_token_valid    = out_data.token_valid;
  assign out_end_of_command = out_data.end_of_command;
  assign out_status         = out_data.status;
  assign out_token_count    = out_data.token_count;

endmodule

`default_nettype wire

// ===== tb/radix40_word_tokenizer_tb.sv =====
`default_nettype none

module radix40_word_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rwt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 90;
  localparam int TARGET_CHARS = 450;

  class token_scoreboard;
    result_t           pending_results[$];
    int                errors;
    int                chars_taken;
    int                busy_chars;
    int                results_seen;
    int                tokens_out;
    int                status_hits[4];
    logic [CHARS_W-1:0] word_len;
    logic [WORD_W-1:0]  acc_first;
    logic [WORD_W-1:0]  acc_second;
    logic [COUNT_W-1:0] kept;
    bit                 overflow_seen;
    mode_t              mode;

    function new();
      errors = 0;
      chars_taken = 0;
      busy_chars = 0;
      results_seen = 0;
      tokens_out = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      clear_command();
      mode = MODE_SCAN;
    endfunction

    function void clear_word();
      word_len = '0;
      acc_first = '0;
      acc_second = '0;
    endfunction

    function void clear_command();
      clear_word();
      kept = '0;
      overflow_seen = 0;
    endfunction

    function logic [CODE_W-1:0] symbol_code(logic [CHAR_W-1:0] c);
      if (c >= CH_A && c <= CH_Z) return CODE_W'(c - CH_A + 8'd1);
      if (c >= CH_ONE && c <= CH_NINE) return CODE_W'(c - CH_ONE + 8'd31);
      if (c == CH_HYPHEN) return HYPHEN_CODE;
      return '0;
    endfunction

    // finish the word in progress; 1 when it is kept as a token
    function bit close_word(inout result_t r);
      if (word_len == 0) return 0;
      if (kept >= TOKEN_LIMIT) begin
        overflow_seen = 1;
        clear_word();
        return 0;
      end
      kept = kept + 1'b1;
      r.first_word = acc_first;
      r.second_word = acc_second;
      r.token_valid = 1'b1;
      tokens_out++;
      clear_word();
      return 1;
    endfunction

    function void predict_char(logic [CHAR_W-1:0] c);
      result_t           r;
      status_t           st;
      logic [CODE_W-1:0] v;
      logic [WORD_W-1:0] weight;
      r = '0;
      chars_taken++;
      if (mode != MODE_DISCARD && !(mode == MODE_CLOSED && c == CH_EOL)) busy_chars++;
      if (mode == MODE_DISCARD) begin
        if (c == CH_EOL) mode = MODE_SCAN;
        return;
      end
      if (mode == MODE_CLOSED) begin
        mode = MODE_SCAN;
        if (c == CH_EOL) return;
      end
      mode = MODE_SCAN;
      if (c == CH_EOL || c == CH_PERIOD || c == CH_COMMA) begin
        void'(close_word(r));
        if (overflow_seen) st = ST_OVERFLOW;
        else if (kept == 0) st = ST_EMPTY;
        else st = ST_OK;
        r.end_of_command = 1'b1;
        r.status = st;
        r.token_count = kept;
        if (c != CH_EOL) mode = (st == ST_OK) ? MODE_CLOSED : MODE_DISCARD;
        clear_command();
        status_hits[st]++;
        pending_results.push_back(r);
        return;
      end
      if (c == CH_SPACE) begin
        if (word_len != 0 && close_word(r)) begin
          r.token_count = kept;
          pending_results.push_back(r);
        end
        return;
      end
      v = symbol_code(c);
      if (v == 0) begin
        r.end_of_command = 1'b1;
        r.status = ST_ILLEGAL;
        r.token_count = kept;
        clear_command();
        mode = MODE_DISCARD;
        status_hits[ST_ILLEGAL]++;
        pending_results.push_back(r);
        return;
      end
      if (word_len < CHAR_LIMIT) begin
        case (word_len % GROUP_SIZE)
          0: weight = WORD_W'(WEIGHT_HIGH);
          1: weight = WORD_W'(WEIGHT_MID);
          default: weight = WORD_W'(1);
        endcase
        if (word_len < GROUP_SIZE) acc_first = acc_first + WORD_W'(v) * weight;
        else acc_second = acc_second + WORD_W'(v) * weight;
        word_len = word_len + 1'b1;
      end
    endfunction

    function void field_ok(string name, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] got);
      if (exp !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: token_valid %0d end_of_command %0d status %0d",
               got.token_valid, got.end_of_command, got.status);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      field_ok("first_word", exp.first_word, got.first_word);
      field_ok("second_word", exp.second_word, got.second_word);
      field_ok("token_valid", WORD_W'(exp.token_valid), WORD_W'(got.token_valid));
      field_ok("end_of_command", WORD_W'(exp.end_of_command), WORD_W'(got.end_of_command));
      field_ok("status", WORD_W'(exp.status), WORD_W'(got.status));
      field_ok("token_count", WORD_W'(exp.token_count), WORD_W'(got.token_count));
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CHAR_W-1:0]  in_character = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [WORD_W-1:0]  out_first_word;
  logic [WORD_W-1:0]  out_second_word;
  logic               out_token_valid;
  logic               out_end_of_command;
  logic [1:0]         out_status;
  logic [COUNT_W-1:0] out_token_count;

  token_scoreboard sb;
  int cycle_count = 0;
  int burst_left = 0;
  bit hold_req = 0;
  bit hold_active = 0;

  radix40_word_tokenizer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_character       (in_character),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_first_word     (out_first_word),
    .out_second_word    (out_second_word),
    .out_token_valid    (out_token_valid),
    .out_end_of_command (out_end_of_command),
    .out_status         (out_status),
    .out_token_count    (out_token_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL radix40_word_tokenizer");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.first_word = out_first_word;
      got.second_word = out_second_word;
      got.token_valid = out_token_valid;
      got.end_of_command = out_end_of_command;
      got.status = status_t'(out_status);
      got.token_count = out_token_count;
      sb.check_result(got);
    end
  end

  // receiver stall patterns, with a long hold-off on request
  initial begin
    int ready_mode;
    int seg;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        hold_active = 1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
        hold_active = 0;
      end else begin
        ready_mode = $urandom_range(0, 3);
        seg = $urandom_range(10, 60);
        repeat (seg) begin
          @(negedge clk);
          case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= (cycle_count % 5 == 0);
          endcase
        end
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_character <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_char(c);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] random_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return CHAR_W'($urandom_range(0, 255));
    if (r < 70) return CH_A + CHAR_W'($urandom_range(0, 25));
    if (r < 90) return CH_ONE + CHAR_W'($urandom_range(0, 8));
    return CH_HYPHEN;
  endfunction

  function automatic int pick_word_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 16) return $urandom_range(19, 24);
    return $urandom_range(1, 6);
  endfunction

  task automatic send_line(input int words);
    int len;
    int r;
    if ($urandom_range(0, 4) == 0) send_char(CH_SPACE);
    for (int w = 0; w < words; w++) begin
      len = (words > 12) ? $urandom_range(1, 3) : $urandom_range(1, 9);
      for (int k = 0; k < len; k++) send_char(random_symbol());
      if (w < words - 1 || $urandom_range(0, 1) == 0) send_char(CH_SPACE);
      if ($urandom_range(0, 5) == 0) send_char(CH_SPACE);
    end
    r = $urandom_range(0, 9);
    if (r < 4) send_char(CH_EOL);
    else begin
      send_char((r < 7) ? CH_PERIOD : CH_COMMA);
      if ($urandom_range(0, 4) < 3) send_char(CH_EOL);
    end
  endtask

  initial begin
    logic [CHAR_W-1:0] directed[] = '{
      CH_SPACE, CH_SPACE, 8'h5A, 8'h59, 8'h58, 8'h57, 8'h56, 8'h55, 8'h54, CH_SPACE,
      CH_HYPHEN, CH_NINE, CH_ONE, CH_PERIOD, CH_EOL,
      CH_COMMA, CH_A, CH_EOL,
      CH_A, 8'hFF, CH_EOL, CH_EOL, 8'h30, CH_EOL, 8'h61, CH_EOL
    };
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_char(directed[i]);
    wait_drained();

    while (sb.busy_chars < TARGET_CHARS / 2) send_line(pick_word_count());

    // long receiver hold-off while the sender keeps going
    @(negedge clk);
    in_valid <= 1'b0;
    hold_req = 1;
    while (!hold_active) @(posedge clk);
    send_line(10);
    wait_drained();

    while (sb.busy_chars < TARGET_CHARS) send_line(pick_word_count());
    send_char(CH_EOL);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("took %0d characters, checked %0d results with %0d tokens",
             sb.chars_taken, sb.results_seen, sb.tokens_out);
    $display("commands closed: ok %0d, empty %0d, illegal %0d, overflow %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY],
             sb.status_hits[ST_ILLEGAL], sb.status_hits[ST_OVERFLOW]);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASS radix40_word_tokenizer");
    end else begin
      $display("FAIL radix40_word_tokenizer");
    end
    $finish;
  end

endmodule

`default_nettype wire
